>>> rtl/ffca_pkg.sv
// Shared types and constants of the first-fit coalescing allocator.
`timescale 1ns / 1ps
package ffca_pkg;

	localparam int unsigned HEADER_BYTES = 12;
	localparam logic [31:0] HEAP_MAGIC = 32'hDEADC0DE;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_OOM     = 2'd1;
	localparam logic [1:0] STAT_DOUBLE  = 2'd2;
	localparam logic [1:0] STAT_CORRUPT = 2'd3;

	typedef struct packed {
		logic        op;
		logic [16:0] need;
		logic [15:0] rel;
		logic        bad;
	} ffca_req_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} ffca_ctl_t;

endpackage

>>> rtl/first_fit_coalescing_allocator.sv
// Top level of the first-fit coalescing heap allocator.
//
//  channel   signals                                    handshake
//  request   req_type, request_bytes, free_addr         start while busy is low
//  result    block_addr, status, used_bytes,            done, one cycle, no stall
//            used_blocks
//
// After reset the heap memory is swept once, one word a cycle, while busy stays high.
// An allocate walks the free list, reading each free block's header, and then takes
// or splits the first block that fits, writing its headers; a free checks the block's
// own header, walks the free blocks below it, reads the next free block above it, and
// writes headers to link and merge. One memory port serves the walk and the writes.
// A two-word queue lets requests be taken while the engine works.
`timescale 1ns / 1ps
module first_fit_coalescing_allocator import ffca_pkg::*; #(
	parameter int unsigned HEAP_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [15:0] request_bytes,
	input  logic [15:0] free_addr,
	output logic        done,
	output logic [15:0] block_addr,
	output logic [1:0]  status,
	output logic [16:0] used_bytes,
	output logic [12:0] used_blocks
);

	ffca_ctl_t ctl;
	ffca_req_t q_head;
	logic      q_valid;

	ffca_front #(.HEAP_BYTES(HEAP_BYTES)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.request_bytes (request_bytes),
		.free_addr     (free_addr),
		.ctl           (ctl),
		.q_valid       (q_valid),
		.q_head        (q_head)
	);

	ffca_back #(.HEAP_BYTES(HEAP_BYTES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.ctl         (ctl),
		.done        (done),
		.block_addr  (block_addr),
		.status      (status),
		.used_bytes  (used_bytes),
		.used_blocks (used_blocks)
	);

endmodule

>>> rtl/ffca_front.sv
// Request front end: accepts words, classifies them and queues them for the engine.
`timescale 1ns / 1ps
module ffca_front import ffca_pkg::*; #(
	parameter int unsigned HEAP_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [15:0] request_bytes,
	input  logic [15:0] free_addr,
	input  ffca_ctl_t   ctl,
	output logic        q_valid,
	output ffca_req_t   q_head
);

	localparam logic [32:0] HEAP_END = 33'(HEAP_BYTES);

	ffca_req_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       pop;
	ffca_req_t  cls;

	assign busy    = (cnt_q == 2'd2) || ctl.clearing;
	assign accept  = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head  = entry_q[rd_ptr_q];
	assign pop     = ctl.pop && q_valid;

	always_comb begin
		cls.op   = req_type;
		cls.need = (17'(request_bytes) + 17'd3) & ~17'd3;
		cls.rel  = free_addr - 16'(HEADER_BYTES);
		cls.bad  = (free_addr < 16'(HEADER_BYTES)) || (free_addr[1:0] != 2'b00) ||
			(33'(free_addr) > HEAP_END);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				entry_q[wr_ptr_q] <= cls;
				wr_ptr_q          <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (accept && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !accept) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/ffca_back.sv
// Allocation engine: heap memory, free-list walk, split and merge sequencer.
`timescale 1ns / 1ps
module ffca_back import ffca_pkg::*; #(
	parameter int unsigned HEAP_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  ffca_req_t   q_head,
	output ffca_ctl_t   ctl,
	output logic        done,
	output logic [15:0] block_addr,
	output logic [1:0]  status,
	output logic [16:0] used_bytes,
	output logic [12:0] used_blocks
);

	localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
	localparam int unsigned IW = $clog2(HEAP_WORDS);
	localparam logic [32:0] HEAP_END = 33'(HEAP_BYTES);
	localparam logic [31:0] LIST_END = 32'(HEAP_BYTES);
	localparam logic [31:0] HDR = 32'(HEADER_BYTES);

	typedef enum logic [27:0] {
		S_IDLE   = 28'd1 << 0,
		S_CLEAR  = 28'd1 << 1,
		S_W_M    = 28'd1 << 2,
		S_W_S    = 28'd1 << 3,
		S_W_L    = 28'd1 << 4,
		S_W_D    = 28'd1 << 5,
		S_W_C1   = 28'd1 << 6,
		S_W_C2   = 28'd1 << 7,
		S_A_FIT  = 28'd1 << 8,
		S_A_W0   = 28'd1 << 9,
		S_A_W1   = 28'd1 << 10,
		S_A_W2   = 28'd1 << 11,
		S_A_W3   = 28'd1 << 12,
		S_A_W4   = 28'd1 << 13,
		S_A_W5   = 28'd1 << 14,
		S_F_S    = 28'd1 << 15,
		S_F_M    = 28'd1 << 16,
		S_F_C1   = 28'd1 << 17,
		S_F_C2   = 28'd1 << 18,
		S_F_LOOP = 28'd1 << 19,
		S_F_W0   = 28'd1 << 20,
		S_F_W1   = 28'd1 << 21,
		S_F_W2   = 28'd1 << 22,
		S_F_W3   = 28'd1 << 23,
		S_F_W4   = 28'd1 << 24,
		S_F_W5   = 28'd1 << 25,
		S_F_W6   = 28'd1 << 26,
		S_F_W7   = 28'd1 << 27
	} state_t;

	logic [31:0] mem [HEAP_WORDS];
	logic [31:0] rdata_q;
	logic        oob_q;
	logic [32:0] mem_addr;
	logic        mem_we;
	logic [31:0] mem_wdata;
	logic        mem_oob;
	logic [31:0] rd_word;

	state_t      state_q;
	logic [IW-1:0] clr_idx_q;
	logic        done_q;
	logic [1:0]  status_q;
	logic [15:0] addr_q;
	logic [31:0] head_q;
	logic [16:0] bytes_q;
	logic [12:0] blocks_q;
	logic        op_q;
	logic        after_q;
	logic [16:0] need_q;
	logic [15:0] r_q;
	logic [31:0] cur_q;
	logic [31:0] prev_q;
	logic        prev_v_q;
	logic [31:0] magic_q;
	logic [31:0] size_q;
	logic [31:0] link_q;
	logic [31:0] repl_q;
	logic [30:0] fsize_q;
	logic [30:0] psize_q;
	logic [31:0] bsize_q;
	logic [31:0] base_q;
	logic [31:0] cost_q;
	logic [32:0] rend_q;

	logic [30:0] sz;
	logic        walk_bad1;
	logic        link_ok;
	logic [31:0] f_cost;

	assign sz      = size_q[30:0];
	assign rd_word = oob_q ? 32'd0 : rdata_q;
	assign mem_oob = (mem_addr >= HEAP_END);

	assign walk_bad1 = (magic_q != HEAP_MAGIC) || size_q[31] || (cur_q[1:0] != 2'b00) ||
		(33'(cur_q) + 33'd12 + 33'(sz) > HEAP_END);
	assign link_ok = (link_q == LIST_END) ||
		((link_q[1:0] == 2'b00) && (link_q > cur_q) && (link_q < LIST_END));
	assign f_cost = 32'(sz) + HDR;

	always_comb begin
		mem_addr  = 33'd0;
		mem_we    = 1'b0;
		mem_wdata = 32'd0;
		case (state_q)
			S_CLEAR: begin
				mem_addr = 33'(clr_idx_q) << 2;
				mem_we   = 1'b1;
				if (clr_idx_q == IW'(0)) begin
					mem_wdata = HEAP_MAGIC;
				end else if (clr_idx_q == IW'(1)) begin
					mem_wdata = LIST_END - HDR;
				end else if (clr_idx_q == IW'(2)) begin
					mem_wdata = LIST_END;
				end
			end
			S_W_M: mem_addr = 33'(cur_q);
			S_W_S: mem_addr = 33'(cur_q) + 33'd4;
			S_W_L: mem_addr = 33'(cur_q) + 33'd8;
			S_F_S: mem_addr = 33'(r_q) + 33'd4;
			S_F_M: mem_addr = 33'(r_q);
			S_A_W0: begin
				mem_addr  = 33'(repl_q);
				mem_we    = 1'b1;
				mem_wdata = HEAP_MAGIC;
			end
			S_A_W1: begin
				mem_addr  = 33'(repl_q) + 33'd4;
				mem_we    = 1'b1;
				mem_wdata = 32'(sz) - 32'(need_q) - HDR;
			end
			S_A_W2: begin
				mem_addr  = 33'(repl_q) + 33'd8;
				mem_we    = 1'b1;
				mem_wdata = link_q;
			end
			S_A_W3: begin
				mem_addr  = 33'(cur_q) + 33'd8;
				mem_we    = 1'b1;
				mem_wdata = LIST_END;
			end
			S_A_W4: begin
				mem_addr  = 33'(cur_q) + 33'd4;
				mem_we    = 1'b1;
				mem_wdata = {1'b1, 31'(need_q)};
			end
			S_A_W5: begin
				mem_addr  = 33'(prev_q) + 33'd8;
				mem_we    = prev_v_q;
				mem_wdata = repl_q;
			end
			S_F_W0: begin
				mem_addr  = 33'(r_q) + 33'd4;
				mem_we    = 1'b1;
				mem_wdata = 32'(fsize_q);
			end
			S_F_W1: begin
				mem_addr  = 33'(r_q) + 33'd8;
				mem_we    = 1'b1;
				mem_wdata = cur_q;
			end
			S_F_W2: begin
				mem_addr  = 33'(prev_q) + 33'd8;
				mem_we    = prev_v_q;
				mem_wdata = 32'(r_q);
			end
			S_F_W3: begin
				mem_addr  = 33'(prev_q) + 33'd4;
				mem_we    = 1'b1;
				mem_wdata = bsize_q;
			end
			S_F_W4: begin
				mem_addr  = 33'(prev_q) + 33'd8;
				mem_we    = 1'b1;
				mem_wdata = cur_q;
			end
			S_F_W6: begin
				mem_addr  = 33'(base_q) + 33'd4;
				mem_we    = 1'b1;
				mem_wdata = bsize_q + 32'(sz) + HDR;
			end
			S_F_W7: begin
				mem_addr  = 33'(base_q) + 33'd8;
				mem_we    = 1'b1;
				mem_wdata = link_q;
			end
			default: begin
				mem_addr = 33'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we && !mem_oob) begin
			mem[mem_addr[IW+1:2]] <= mem_wdata;
		end
		rdata_q <= mem[mem_addr[IW+1:2]];
		oob_q   <= mem_oob;
	end

	assign ctl.clearing = (state_q == S_CLEAR);
	assign ctl.pop      = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_idx_q <= '0;
			done_q    <= 1'b0;
			status_q  <= STAT_OK;
			addr_q    <= 16'd0;
			head_q    <= 32'd0;
			bytes_q   <= 17'd0;
			blocks_q  <= 13'd0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IW'(1);
					if (clr_idx_q == IW'(HEAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						op_q     <= q_head.op;
						need_q   <= q_head.need;
						r_q      <= q_head.rel;
						prev_v_q <= 1'b0;
						after_q  <= 1'b0;
						cur_q    <= head_q;
						if (q_head.op == OP_ALLOC) begin
							if (head_q == LIST_END) begin
								done_q   <= 1'b1;
								status_q <= STAT_OOM;
								addr_q   <= 16'd0;
							end else begin
								state_q <= S_W_M;
							end
						end else if (q_head.bad) begin
							done_q   <= 1'b1;
							status_q <= STAT_CORRUPT;
							addr_q   <= 16'd0;
						end else begin
							state_q <= S_F_S;
						end
					end
				end
				S_W_M: state_q <= S_W_S;
				S_W_S: begin
					magic_q <= rd_word;
					state_q <= S_W_L;
				end
				S_W_L: begin
					size_q  <= rd_word;
					state_q <= S_W_D;
				end
				S_W_D: begin
					link_q  <= rd_word;
					state_q <= S_W_C1;
				end
				S_W_C1: begin
					if (walk_bad1) begin
						done_q   <= 1'b1;
						status_q <= STAT_CORRUPT;
						addr_q   <= 16'd0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_W_C2;
					end
				end
				S_W_C2: begin
					if (!link_ok) begin
						done_q   <= 1'b1;
						status_q <= STAT_CORRUPT;
						addr_q   <= 16'd0;
						state_q  <= S_IDLE;
					end else if (op_q == OP_ALLOC) begin
						state_q <= S_A_FIT;
					end else if (after_q) begin
						state_q <= S_F_W0;
					end else begin
						prev_q   <= cur_q;
						prev_v_q <= 1'b1;
						psize_q  <= sz;
						cur_q    <= link_q;
						state_q  <= S_F_LOOP;
					end
				end
				S_A_FIT: begin
					if (33'(sz) == 33'(need_q)) begin
						repl_q  <= link_q;
						state_q <= S_A_W4;
					end else if (33'(sz) >= 33'(need_q) + 33'd16) begin
						repl_q  <= cur_q + HDR + 32'(need_q);
						state_q <= S_A_W0;
					end else if (link_q == LIST_END) begin
						done_q   <= 1'b1;
						status_q <= STAT_OOM;
						addr_q   <= 16'd0;
						state_q  <= S_IDLE;
					end else begin
						prev_q   <= cur_q;
						prev_v_q <= 1'b1;
						cur_q    <= link_q;
						state_q  <= S_W_M;
					end
				end
				S_A_W0: state_q <= S_A_W1;
				S_A_W1: state_q <= S_A_W2;
				S_A_W2: state_q <= S_A_W3;
				S_A_W3: state_q <= S_A_W4;
				S_A_W4: state_q <= S_A_W5;
				S_A_W5: begin
					if (!prev_v_q) begin
						head_q <= repl_q;
					end
					bytes_q  <= bytes_q + need_q + 17'(HEADER_BYTES);
					blocks_q <= blocks_q + 13'd1;
					done_q   <= 1'b1;
					status_q <= STAT_OK;
					addr_q   <= 16'(cur_q + HDR);
					state_q  <= S_IDLE;
				end
				S_F_S: state_q <= S_F_M;
				S_F_M: begin
					size_q  <= rd_word;
					state_q <= S_F_C1;
				end
				S_F_C1: begin
					if (!size_q[31]) begin
						done_q   <= 1'b1;
						status_q <= STAT_DOUBLE;
						addr_q   <= 16'd0;
						state_q  <= S_IDLE;
					end else if (rd_word != HEAP_MAGIC) begin
						done_q   <= 1'b1;
						status_q <= STAT_CORRUPT;
						addr_q   <= 16'd0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_F_C2;
					end
				end
				S_F_C2: begin
					fsize_q <= sz;
					bsize_q <= 32'(sz);
					base_q  <= 32'(r_q);
					cost_q  <= f_cost;
					rend_q  <= 33'(r_q) + 33'd12 + 33'(sz);
					if ((33'(r_q) + 33'd12 + 33'(sz) > HEAP_END) ||
						(f_cost > 32'(bytes_q)) || (blocks_q == 13'd0)) begin
						done_q   <= 1'b1;
						status_q <= STAT_CORRUPT;
						addr_q   <= 16'd0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_F_LOOP;
					end
				end
				S_F_LOOP: begin
					if (cur_q < 32'(r_q)) begin
						state_q <= S_W_M;
					end else if (cur_q == 32'(r_q)) begin
						done_q   <= 1'b1;
						status_q <= STAT_CORRUPT;
						addr_q   <= 16'd0;
						state_q  <= S_IDLE;
					end else if (cur_q == LIST_END) begin
						state_q <= S_F_W0;
					end else begin
						after_q <= 1'b1;
						state_q <= S_W_M;
					end
				end
				S_F_W0: state_q <= S_F_W1;
				S_F_W1: state_q <= S_F_W2;
				S_F_W2: begin
					if (!prev_v_q) begin
						head_q  <= 32'(r_q);
						state_q <= S_F_W5;
					end else if (33'(prev_q) + 33'd12 + 33'(psize_q) == 33'(r_q)) begin
						bsize_q <= 32'(psize_q) + 32'(fsize_q) + HDR;
						state_q <= S_F_W3;
					end else begin
						state_q <= S_F_W5;
					end
				end
				S_F_W3: state_q <= S_F_W4;
				S_F_W4: begin
					base_q  <= prev_q;
					state_q <= S_F_W5;
				end
				S_F_W5: begin
					if ((cur_q != LIST_END) && (rend_q == 33'(cur_q))) begin
						state_q <= S_F_W6;
					end else begin
						bytes_q  <= bytes_q - 17'(cost_q);
						blocks_q <= blocks_q - 13'd1;
						done_q   <= 1'b1;
						status_q <= STAT_OK;
						addr_q   <= 16'd0;
						state_q  <= S_IDLE;
					end
				end
				S_F_W6: state_q <= S_F_W7;
				S_F_W7: begin
					bytes_q  <= bytes_q - 17'(cost_q);
					blocks_q <= blocks_q - 13'd1;
					done_q   <= 1'b1;
					status_q <= STAT_OK;
					addr_q   <= 16'd0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign block_addr  = addr_q;
	assign status      = status_q;
	assign used_bytes  = bytes_q;
	assign used_blocks = blocks_q;

	// A failed request returns no address.
	a_err_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != STAT_OK) |-> addr_q == 16'd0)
		else $error("error result carries an address");

	// Every result closes the request and leaves the engine idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result issued while engine still working");

	// No result appears during the clearing pass.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !done_q)
		else $error("result during clearing pass");

	// A failed request leaves the usage counts untouched.
	a_err_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != STAT_OK) |->
		(bytes_q == $past(bytes_q)) && (blocks_q == $past(blocks_q)))
		else $error("counts changed on a failed request");

endmodule
